// ----- sv/pcxrle_pkg.sv -----
// shared types and constants for the pcx run-length pixel-pair decoder
package pcxrle_pkg;

    // byte classification
    localparam logic [7:0] HDR_MASK = 8'hc0;
    localparam logic [7:0] CNT_MASK = 8'h3f;
    localparam int unsigned CNT_W   = 6;
    // words per input byte reach 32; the word counter is one bit wider than the count
    localparam int unsigned WORDS_W = CNT_W + 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } pcxrle_in_t;

    typedef struct packed {
        logic [15:0] pixel_pair;
        logic        last_of_run;
    } pcxrle_out_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } pcxrle_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic advance;
    } pcxrle_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic has_words;
        logic last_word;
    } pcxrle_sts_t;

endpackage

// ----- sv/pcxrle_datapath.sv -----
// datapath: run and pairing state, word counter and output word register
module pcxrle_datapath
    import pcxrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pcxrle_in_t  in_data,
    input  pcxrle_cmd_t cmd,
    output pcxrle_sts_t sts,
    output pcxrle_out_t out_data
);

    logic               run_pending_reg, run_pending_next;
    logic [CNT_W-1:0]   run_count_reg, run_count_next;
    logic               pixel_held_reg, pixel_held_next;
    logic [7:0]         held_pixel_reg, held_pixel_next;
    logic [WORDS_W-1:0] words_left_reg, words_left_next;
    logic [7:0]         run_byte_reg, run_byte_next;
    logic [15:0]        word_reg, word_next;

    logic               is_hdr;
    logic [CNT_W-1:0]   eff_count;
    logic [WORDS_W:0]   pixels;
    logic [WORDS_W-1:0] start_words;

    // pixels this byte adds to the pairer, plus a held one
    always_comb
    begin
        is_hdr = (in_data.data_byte & HDR_MASK) == HDR_MASK;
        if (run_pending_reg)
            eff_count = run_count_reg;
        else if (is_hdr)
            eff_count = '0;
        else
            eff_count = CNT_W'(1);
        pixels      = (WORDS_W + 1)'(eff_count) + (WORDS_W + 1)'(pixel_held_reg);
        start_words = pixels[WORDS_W:1];
    end

    // next state of the decoder
    always_comb
    begin
        run_pending_next = run_pending_reg;
        run_count_next   = run_count_reg;
        pixel_held_next  = pixel_held_reg;
        held_pixel_next  = held_pixel_reg;
        words_left_next  = words_left_reg;
        run_byte_next    = run_byte_reg;
        word_next        = word_reg;
        if (cmd.load)
        begin
            if (run_pending_reg)
            begin
                run_pending_next = 1'b0;
                run_count_next   = '0;
            end
            else if (is_hdr && !in_data.final_byte)
            begin
                run_pending_next = 1'b1;
                run_count_next   = CNT_W'(in_data.data_byte & CNT_MASK);
            end
            pixel_held_next = pixels[0];
            if (pixels[0] && (eff_count != '0))
                held_pixel_next = in_data.data_byte;
            words_left_next = start_words;
            run_byte_next   = in_data.data_byte;
            word_next       = {(pixel_held_reg ? held_pixel_reg : in_data.data_byte),
                               in_data.data_byte};
        end
        else if (cmd.advance)
        begin
            words_left_next = words_left_reg - WORDS_W'(1);
            word_next       = {run_byte_reg, run_byte_reg};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pending_reg <= 1'b0;
            run_count_reg   <= '0;
            pixel_held_reg  <= 1'b0;
            held_pixel_reg  <= '0;
            words_left_reg  <= '0;
        end
        else
        begin
            run_pending_reg <= run_pending_next;
            run_count_reg   <= run_count_next;
            pixel_held_reg  <= pixel_held_next;
            held_pixel_reg  <= held_pixel_next;
            words_left_reg  <= words_left_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        run_byte_reg <= run_byte_next;
        word_reg     <= word_next;
    end

    assign sts.has_words        = start_words != '0;
    assign sts.last_word        = words_left_reg == WORDS_W'(1);
    assign out_data.pixel_pair  = word_reg;
    assign out_data.last_of_run = sts.last_word;

endmodule

// ----- sv/pcxrle_ctrl.sv -----
// controller: takes a request, then emits its words one per cycle while out_ready is high
module pcxrle_ctrl
    import pcxrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  pcxrle_sts_t sts,
    output pcxrle_cmd_t cmd
);

    pcxrle_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.has_words)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready && sts.last_word)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_EMIT: out_valid = 1'b1;
            default: in_ready  = 1'b0;
        endcase
        cmd.load    = in_valid && in_ready;
        cmd.advance = out_valid && out_ready;
    end

endmodule

// ----- sv/pcx_rle_pixel_pair_decoder_core.sv -----
// top level of the pcx 8-bit run-length pixel-pair decoder
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_data  (data_byte, final_byte)
//  out     | output    | out_valid / out_ready | out_data (pixel_pair, last_of_run)
//
// a request that makes no word (header, first pixel of a pair) leaves the block ready
// a request that makes n words, n up to 32, is emitted from the
// single output word register that the word counter steps through
// rst_n clears run, pairing and handshake state asynchronously
// a stalled output holds the word and keeps in_ready low
module pcx_rle_pixel_pair_decoder_core
    import pcxrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pcxrle_in_t  in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pcxrle_out_t out_data
);

    pcxrle_cmd_t cmd;
    pcxrle_sts_t sts;

    // sequencing
    pcxrle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // decoding state and words
    pcxrle_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    // never both sides open at once
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid both high");

    // words keep coming until the last one is taken
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_of_run) |=> out_valid)
        else $error("word sequence ended early");

    // after the last word the block takes requests again
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last_of_run) |=> in_ready)
        else $error("not ready after last word");

    // a request that makes words opens the output next cycle
    a_start_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && sts.has_words) |=> out_valid)
        else $error("words not emitted");
`endif

endmodule

// ----- verif/pcx_rle_pixel_pair_decoder_core_tb.sv -----
// self-checking testbench for the pcx run-length pixel-pair decoder core
`timescale 1ns / 100ps

module pcx_rle_pixel_pair_decoder_core_tb;
    import pcxrle_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    pcxrle_in_t  in_data;
    logic        out_valid;
    logic        out_ready;
    pcxrle_out_t out_data;

    // decoder state as the testbench sees it
    logic              run_armed;
    logic [CNT_W-1:0]  run_len;
    logic              half_valid;
    logic [7:0]        half_pixel;
    pcxrle_out_t       expected_words[$];

    // stimulus and receiver controls
    bit src_idle_on;
    bit sink_idle_on;
    int hold_left;
    int stall_left;

    // bookkeeping
    int cycle_count;
    int mismatches;
    int requests_sent;
    int words_checked;
    int runs_seen;
    int empty_runs;
    int dangling_headers;
    int full_steps;

    pcx_rle_pixel_pair_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 50 MHz clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // feed one pixel to the pairer, returns 1 when a word completes
    function automatic int pair_pixel(logic [7:0] px);
        pcxrle_out_t word;
        if (half_valid)
        begin
            word.pixel_pair  = {half_pixel, px};
            word.last_of_run = 1'b0;
            expected_words.push_back(word);
            half_valid = 1'b0;
            return 1;
        end
        half_pixel = px;
        half_valid = 1'b1;
        return 0;
    endfunction

    // work out the words one accepted byte produces
    function automatic void predict_words(pcxrle_in_t req);
        int         n;
        int         k;
        logic [7:0] masked;
        n = 0;
        if (run_armed)
        begin
            runs_seen++;
            if (run_len == 0)
                empty_runs++;
            for (k = 0; k < run_len; k++)
                n += pair_pixel(req.data_byte);
            run_armed = 1'b0;
            run_len   = '0;
        end
        else if ((req.data_byte & HDR_MASK) == HDR_MASK)
        begin
            if (!req.final_byte)
            begin
                masked    = req.data_byte & CNT_MASK;
                run_armed = 1'b1;
                run_len   = masked[CNT_W-1:0];
            end
            else
                dangling_headers++;
        end
        else
            n += pair_pixel(req.data_byte);
        if (n > 0)
            expected_words[expected_words.size()-1].last_of_run = 1'b1;
        if (n == 32)
            full_steps++;
    endfunction

    function automatic logic [7:0] run_header(int count);
        return HDR_MASK | 8'(count);
    endfunction

    // offer one request, optionally after an idle burst, and wait for it to be taken
    task automatic send_byte(logic [7:0] b, logic fin);
        pcxrle_in_t req;
        req.data_byte  = b;
        req.final_byte = fin;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_words(req);
        requests_sent++;
    endtask

    task automatic idle_input(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_all_words();
        idle_input(1);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(string what, int exp_val, int act_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at word %0d: %s expected %h actual %h",
                     words_checked, what, exp_val, act_val);
    endtask

    // receiver: long hold-offs, random stall bursts, otherwise ready
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // compare every accepted word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                flag_mismatch("unexpected word", 0, out_data.pixel_pair);
            else
            begin
                if (out_data.pixel_pair !== expected_words[0].pixel_pair)
                    flag_mismatch("pixel_pair", expected_words[0].pixel_pair,
                                  out_data.pixel_pair);
                if (out_data.last_of_run !== expected_words[0].last_of_run)
                    flag_mismatch("last_of_run", expected_words[0].last_of_run,
                                  out_data.last_of_run);
                void'(expected_words.pop_front());
            end
            words_checked++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("pcx_rle_pixel_pair_decoder_core regression: fail");
            $finish;
        end
    end

    // literals at the byte extremes, pairing, final flag without flush
    task automatic test_literals();
        send_byte(8'h00, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h3f, 1'b1);
        send_byte(8'h40, 1'b0);
    endtask

    // runs: header-like run pixel, empty run, dangling header,
    // final flag on a run pixel, longest run across a held pixel
    task automatic test_runs();
        send_byte(8'h01, 1'b0);
        send_byte(run_header(1), 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(run_header(0), 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(run_header(5), 1'b1);
        send_byte(run_header(2), 1'b0);
        send_byte(run_header(2), 1'b0);
        send_byte(run_header(3), 1'b0);
        send_byte(8'haa, 1'b1);
        send_byte(run_header(63), 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // receiver holds off while long runs and literals keep coming
    task automatic test_output_hold();
        hold_left = 300;
        send_byte(run_header(63), 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(run_header(40), 1'b0);
        send_byte(8'ha5, 1'b0);
        repeat (4) send_byte(8'($urandom_range(0, 8'hbf)), 1'b0);
        wait_all_words();
    endtask

    // mostly well-formed runs and literals with random content, some noise
    task automatic test_random_stream(int count);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_byte(8'($urandom_range(0, 8'hbf)), ($urandom_range(0, 9) == 0));
                sent++;
            end
            else if (pick < 85)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 7);
                send_byte(run_header(len), 1'b0);
                send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
                sent += 2;
            end
            else if (pick < 92)
            begin
                send_byte(run_header($urandom_range(0, 63)), 1'b1);
                sent++;
            end
            else
            begin
                send_byte(8'($urandom), 1'($urandom));
                sent++;
            end
            // occasional full drain, only while idling is allowed
            if (src_idle_on && $urandom_range(0, 40) == 0)
                wait_all_words();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        run_armed    = 1'b0;
        run_len      = '0;
        half_valid   = 1'b0;
        half_pixel   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_literals();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_runs();
        test_output_hold();
        test_random_stream(70);
        // last stretch at full rate on both sides
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_stream(25);

        wait_all_words();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            flag_mismatch("words never delivered", expected_words.size(), 0);

        $display("sent %0d requests, checked %0d words over %0d runs",
                 requests_sent, words_checked, runs_seen);
        $display("empty runs %0d, dropped headers %0d, 32-word requests %0d, mismatches %0d",
                 empty_runs, dangling_headers, full_steps, mismatches);
        if (mismatches == 0)
            $display("pcx_rle_pixel_pair_decoder_core regression: pass");
        else
            $display("pcx_rle_pixel_pair_decoder_core regression: fail");
        $finish;
    end

endmodule
